### rtl/lbf_pkg.sv
// shared types and constants for the led blink frame encoder
// no dependencies; imported by every module of the block

package lbf_pkg;

	// frame layout
	localparam int POS_W       = 7;
	localparam int CHAR_W      = 7;
	localparam int FRAME_BITS  = POS_W + CHAR_W;
	localparam int FRAME_TICKS = 51;
	localparam int DELIM_TICKS = 9;
	localparam int TICK_W      = $clog2(FRAME_TICKS);
	localparam int BIT_W       = $clog2(FRAME_BITS);

	// delimiter: off 2, on 5, off 2
	localparam logic [TICK_W-1:0] DELIM_ON_FIRST = TICK_W'(2);
	localparam logic [TICK_W-1:0] DELIM_ON_LAST  = TICK_W'(6);
	localparam logic [TICK_W-1:0] DELIM_END      = TICK_W'(DELIM_TICKS);
	localparam logic [TICK_W-1:0] TICK_LAST      = TICK_W'(FRAME_TICKS - 1);

	// phases of one data bit
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_MIDDLE = 2'd1,
		PH_FINAL  = 2'd2
	} lbf_phase_t;

	// one queued frame request
	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [CHAR_W-1:0] ch;
	} lbf_entry_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} lbf_qstat_t;

endpackage

### rtl/lbf_front.sv
// front end: accepts characters, tracks the wrapping position, builds frame words
// depends on lbf_pkg

module lbf_front import lbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] char_code
	input  logic             s_tuser,   // [0] restart
	input  lbf_qstat_t       qstat,
	output logic             push,
	output lbf_entry_t       push_entry
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_now;

	// request is taken whenever the queue has room
	assign s_tready = ~qstat.full;
	assign push     = s_tvalid & s_tready;

	// restart clears the position before this frame
	assign pos_now        = s_tuser ? '0 : pos_q;
	assign push_entry.pos = pos_now;
	assign push_entry.ch  = s_tdata[CHAR_W-1:0];

	// position advances once per accepted request, wraps naturally
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= pos_now + POS_W'(1);
		end
	end

endmodule

### rtl/lbf_queue.sv
// two-entry queue of frame words between front and back
// depends on lbf_pkg

module lbf_queue import lbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  lbf_entry_t push_entry,
	input  logic       pop,
	output lbf_entry_t head,
	output lbf_qstat_t qstat
);

	lbf_entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### rtl/lbf_back.sv
// back end: serializes one frame word into 51 led ticks with a registered output
// depends on lbf_pkg

module lbf_back import lbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lbf_entry_t head,
	input  lbf_qstat_t qstat,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] led_on, [7:1] zero
	output logic       m_tlast    // last_tick
);

	logic [FRAME_BITS-1:0] word_q;
	logic                  busy_q;
	logic [TICK_W-1:0]     tick_q;
	logic [BIT_W-1:0]      bit_q;
	lbf_phase_t            ph_q;
	logic                  out_valid_q;
	logic                  out_led_q;
	logic                  out_last_q;

	logic advance;
	logic is_last;
	logic level;
	logic data_bit;

	assign advance = busy_q & (~out_valid_q | m_tready);
	assign is_last = (tick_q == TICK_LAST);
	assign pop     = ~qstat.empty & (~busy_q | (advance & is_last));

	// level of the current tick
	always_comb begin
		data_bit = word_q[bit_q];
		if (tick_q < DELIM_END) begin
			level = (tick_q >= DELIM_ON_FIRST) && (tick_q <= DELIM_ON_LAST);
		end else begin
			case (ph_q)
				PH_FIRST:  level = data_bit;
				PH_MIDDLE: level = 1'b0;
				PH_FINAL:  level = ~data_bit;
				default:   level = 1'b0;
			endcase
		end
	end

	// frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tick_q <= '0;
			bit_q  <= '0;
			ph_q   <= PH_FIRST;
		end else if (pop) begin
			busy_q <= 1'b1;
			tick_q <= '0;
			bit_q  <= BIT_W'(FRAME_BITS - 1);
			ph_q   <= PH_FIRST;
		end else if (advance) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			tick_q <= tick_q + TICK_W'(1);
			if (tick_q >= DELIM_END) begin
				case (ph_q)
					PH_FIRST:  ph_q <= PH_MIDDLE;
					PH_MIDDLE: ph_q <= PH_FINAL;
					default: begin
						ph_q  <= PH_FIRST;
						bit_q <= bit_q - BIT_W'(1);
					end
				endcase
			end
		end
	end

	// frame word
	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= {head.pos, head.ch};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_led_q  <= level;
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_led_q};
	assign m_tlast  = out_last_q;

endmodule

### rtl/led_blink_frame_encoder_unit.sv
// each request passes the queue, the frame word register and the output register;
// one led tick per cycle unless m_tready stalls, 51 ticks per character, set by
// the back end tick sequencer; the two-entry queue takes requests during a frame
// reset: arst_n clears the position counter, the queue and the output valid
// depends on lbf_pkg, lbf_front, lbf_queue, lbf_back

module led_blink_frame_encoder_unit import lbf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tuser,   // [0] restart
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] led_on, [7:1] zero
	output logic       m_tlast    // last_tick
);

	lbf_qstat_t qstat;
	lbf_entry_t push_entry;
	lbf_entry_t head;
	logic       push;
	logic       pop;

	// request intake and position tracking
	lbf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	lbf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// tick serializer
	lbf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### tb/lbf_tb_pkg.sv
// tick scoreboard for the led blink frame encoder testbench
// depends on lbf_pkg for the frame layout and the bit phase codes

package lbf_tb_pkg;
	import lbf_pkg::*;

	class frame_scoreboard;
		// one expected led tick
		typedef struct packed {
			logic led_on;
			logic last_tick;
		} tick_t;

		tick_t            ticks_due[$];
		logic [POS_W-1:0] position;
		int               n_chars;
		int               n_restarts;
		int               n_wraps;
		int               n_ticks;
		int               n_errors;

		function new();
			position   = '0;
			n_chars    = 0;
			n_restarts = 0;
			n_wraps    = 0;
			n_ticks    = 0;
			n_errors   = 0;
		endfunction

		// expand one accepted request into its 51 expected led ticks
		function void note_char(logic [7:0] char_code, logic restart);
			logic [FRAME_BITS-1:0] word;
			tick_t                 tk;
			lbf_phase_t            ph;
			logic                  bit_val;
			int                    rel;
			if (restart) begin
				position = '0;
				n_restarts++;
			end
			word = {position, char_code[CHAR_W-1:0]};
			for (int t = 0; t < FRAME_TICKS; t++) begin
				if (t < DELIM_TICKS) begin
					// delimiter: off 2, on 5, off 2
					tk.led_on = (t >= 2) && (t <= 6);
				end else begin
					// data bits msb first, three ticks each
					rel        = t - DELIM_TICKS;
					ph         = lbf_phase_t'(rel % 3);
					bit_val    = word[FRAME_BITS - 1 - rel / 3];
					tk.led_on  = bit_val ? (ph == PH_FIRST) : (ph == PH_FINAL);
				end
				tk.last_tick = (t == FRAME_TICKS - 1);
				ticks_due.push_back(tk);
			end
			if (position == {POS_W{1'b1}})
				n_wraps++;
			position = position + POS_W'(1);
			n_chars++;
		endfunction

		// compare one accepted output tick with the oldest expectation
		function void check_tick(logic [7:0] data, logic last);
			tick_t tk;
			if (ticks_due.size() == 0) begin
				$error("tick with no frame pending: led_on %0d last_tick %0d", data[0], last);
				n_errors++;
				return;
			end
			tk = ticks_due.pop_front();
			n_ticks++;
			if (data[0] !== tk.led_on) begin
				$error("led_on: expected %0d, got %0d", tk.led_on, data[0]);
				n_errors++;
			end
			if (last !== tk.last_tick) begin
				$error("last_tick: expected %0d, got %0d", tk.last_tick, last);
				n_errors++;
			end
			if (data[7:1] !== 7'd0) begin
				$error("tdata pad: expected 0, got %0h", data[7:1]);
				n_errors++;
			end
		endfunction

		function int pending();
			return ticks_due.size();
		endfunction
	endclass

endpackage

### tb/tb_top.sv
// top level testbench for led_blink_frame_encoder_unit
// drives character requests, stalls the led stream, checks every tick
// depends on lbf_pkg and lbf_tb_pkg

module tb_top import lbf_pkg::*; import lbf_tb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS  = 128;
	localparam int DIR_ITEMS   = 14;
	localparam int DRAIN       = 20;
	localparam int STALL_LIMIT = 1000;

	// directed characters: extremes, bit 7 set, alternating patterns
	localparam logic [7:0] DIR_CODES [DIR_ITEMS] = '{
		8'h00, 8'h7F, 8'h80, 8'hFF, 8'h55, 8'hAA, 8'h01,
		8'h40, 8'h2A, 8'h7E, 8'h3C, 8'h81, 8'hC3, 8'h00
	};
	// restart on the first request and again right after it
	localparam bit DIR_RESTART [DIR_ITEMS] = '{
		1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
	};

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] char_code
	logic       s_tuser;   // [0] restart
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [0] led_on, [7:1] zero
	logic       m_tlast;   // last_tick

	bit              calm        = 1'b0;
	int              idle_cycles = 0;
	frame_scoreboard sb          = new();

	led_blink_frame_encoder_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// send one character request, optionally after a short gap
	task automatic send_char(input logic [7:0] code, input logic restart, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		s_tuser  <= restart;
		do @(posedge clk); while (!s_tready);
		sb.note_char(code, restart);
	endtask

	// led stream sink with random stall bursts
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 11) == 0) begin
				stall = $urandom_range(1, 8);
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// check every accepted tick
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_tick(m_tdata, m_tlast);
	end

	// watchdog on cycles with no request or tick moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// reset, directed requests, random requests, drain
	initial begin
		logic [7:0] code;
		logic       restart;
		bit         quiet;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'd0;
		s_tuser  <= 1'b0;
		arst_n   <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ITEMS; i++)
			send_char(DIR_CODES[i], DIR_RESTART[i], 1'b1);

		// long run without restart so the position wraps, restarts near the end
		for (int i = 0; i < RAND_ITEMS; i++) begin
			quiet   = (i % 40 >= 28) || (i >= RAND_ITEMS - 20);
			calm   <= quiet;
			code    = 8'($urandom_range(0, 255));
			restart = (i >= RAND_ITEMS - 8) && ($urandom_range(0, 3) == 0);
			send_char(code, restart, !quiet);
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("sent %0d characters, %0d with restart, %0d position wraps",
			sb.n_chars, sb.n_restarts, sb.n_wraps);
		$display("checked %0d led ticks under random source gaps and sink stalls", sb.n_ticks);
		if (sb.n_errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/lbf_pkg.sv
rtl/lbf_front.sv
rtl/lbf_queue.sv
rtl/lbf_back.sv
rtl/led_blink_frame_encoder_unit.sv
tb/lbf_tb_pkg.sv
tb/tb_top.sv
